FILE: rtl/pdba_pkg.sv
// Shared types, codes and pixel helpers for the palette downscaler.
// Used by pdba_frame_mem, pdba_pal_mem and palette_downscale_box_average.
// No dependencies.
package pdba_pkg;

    // request action codes
    localparam logic [1:0] ACT_LOAD_PAL = 2'd0;
    localparam logic [1:0] ACT_LOAD_PIX = 2'd1;
    localparam logic [1:0] ACT_REQ_PAIR = 2'd2;

    // configuration register indexes
    localparam logic CFG_SRC_WIDTH  = 1'b0;
    localparam logic CFG_SRC_HEIGHT = 1'b1;
    localparam int   CFG_DATA_W     = 9;

    // carry-free RGB565 halving mask
    localparam logic [15:0] AVG_MASK = 16'hF7DE;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  pal_index;
        logic [15:0] color;
        logic [7:0]  src_row;
        logic [7:0]  src_col;
        logic [7:0]  pixel_code;
        logic [6:0]  pair_x;
        logic [6:0]  line_y;
        logic        blank;
    } pdba_in_t;

    typedef struct packed {
        logic [31:0] pair_word;
        logic [6:0]  echo_x;
        logic [6:0]  echo_y;
    } pdba_out_t;

    // frame store write request
    typedef struct packed {
        logic       en;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] code;
    } pdba_pix_wr_t;

    // palette write request
    typedef struct packed {
        logic        en;
        logic [7:0]  index;
        logic [15:0] color;
    } pdba_pal_wr_t;

    // per-channel average, rounding down, no carry between channels
    function automatic logic [15:0] avg565(input logic [15:0] a, input logic [15:0] b);
        return 16'((((a ^ b) & AVG_MASK) >> 1) + (a & b));
    endfunction

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

endpackage

FILE: rtl/palette_downscale_box_average.sv
// A request moves through stages 1 to 7 and then the output register to m_data.
// Throughput: one item per cycle; a stalled m_ready holds the pipeline and
// bubbles are squeezed out, so s_ready only drops when every stage is full.
// Reset (synchronous, aresetn low) empties the pipeline and sets the source
// size to 256x240; palette and frame contents are undefined until written.
module palette_downscale_box_average #(
    parameter int OUT_WIDTH     = 160,
    parameter int OUT_HEIGHT    = 128,
    parameter int SRC_MAX_DIM   = 256,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [pdba_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pdba_pkg::pdba_in_t            s_data,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output pdba_pkg::pdba_out_t           m_data
);

    localparam int CW   = $clog2(SRC_MAX_DIM);       // coordinate width
    localparam int DW   = $clog2(SRC_MAX_DIM + 1);   // dimension width
    localparam int PN   = 8 + DW;                    // scaled product width
    localparam int MW   = PN + 2;                    // reciprocal width
    localparam int QW   = PN + MW;
    localparam int S_C  = PN + $clog2(OUT_WIDTH);
    localparam int S_R  = PN + $clog2(OUT_HEIGHT);
    localparam logic [63:0] RECIP_C64 =
        ((64'd1 << S_C) + 64'(OUT_WIDTH) - 64'd1) / 64'(OUT_WIDTH);
    localparam logic [63:0] RECIP_R64 =
        ((64'd1 << S_R) + 64'(OUT_HEIGHT) - 64'd1) / 64'(OUT_HEIGHT);
    localparam logic [MW-1:0] RECIP_C = MW'(RECIP_C64);
    localparam logic [MW-1:0] RECIP_R = MW'(RECIP_R64);
    localparam logic [DW-1:0] W_RST = DW'((256 > SRC_MAX_DIM) ? SRC_MAX_DIM : 256);
    localparam logic [DW-1:0] H_RST = DW'((240 > SRC_MAX_DIM) ? SRC_MAX_DIM : 240);

    typedef struct packed {
        logic [1:0] action;
        logic       blank;
        logic [6:0] pair_x;
        logic [6:0] line_y;
    } req_t;

    // saturate a written size to the usable range
    function automatic logic [DW-1:0] clamp_dim(input logic [pdba_pkg::CFG_DATA_W-1:0] v);
        logic [31:0] r;
        r = 32'(v);
        if (r < 32'd2) begin
            r = 32'd2;
        end else if (r > 32'(SRC_MAX_DIM)) begin
            r = 32'(SRC_MAX_DIM);
        end
        return DW'(r);
    endfunction

    // ---------------- configuration ----------------
    logic [DW-1:0] w_reg, h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= W_RST;
            h_reg <= H_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pdba_pkg::CFG_SRC_WIDTH:  w_reg <= clamp_dim(cfg_wdata);
                pdba_pkg::CFG_SRC_HEIGHT: h_reg <= clamp_dim(cfg_wdata);
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic [7:1] vld_reg, vld_next;
    logic [7:1] adv;
    logic [8:1] free;
    logic       s_accept;
    logic       m_valid_reg;

    always_comb begin
        free[8] = !m_valid_reg || m_ready;
        for (int k = 7; k >= 1; k--) begin
            adv[k]  = vld_reg[k] && free[k+1];
            free[k] = !vld_reg[k] || adv[k];
        end
    end

    assign s_ready  = free[1];
    assign s_accept = s_valid && s_ready;

    always_comb begin
        vld_next = vld_reg;
        if (free[1]) begin
            vld_next[1] = s_accept;
        end
        for (int k = 2; k <= 7; k++) begin
            if (free[k]) begin
                vld_next[k] = adv[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- stage 1: input register ----------------
    pdba_pkg::pdba_in_t it1_reg, it2_reg, it3_reg, it4_reg, it5_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            it1_reg <= s_data;
        end
    end

    // ---------------- stage 2: position times source size ----------------
    logic [PN-1:0] pr2_reg, pc0_2_reg, pc1_2_reg;
    logic [PN-1:0] pr2_next, pc0_2_next, pc1_2_next;

    always_comb begin
        pr2_next   = PN'(it1_reg.line_y) * PN'(h_reg);
        pc0_2_next = PN'({it1_reg.pair_x, 1'b0}) * PN'(w_reg);
        pc1_2_next = PN'({it1_reg.pair_x, 1'b1}) * PN'(w_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            it2_reg   <= it1_reg;
            pr2_reg   <= pr2_next;
            pc0_2_reg <= pc0_2_next;
            pc1_2_reg <= pc1_2_next;
        end
    end

    // ---------------- stage 3: divide by display size via reciprocal ----------------
    logic [PN-1:0] qr3_reg, qc0_3_reg, qc1_3_reg;
    logic [PN-1:0] qr3_next, qc0_3_next, qc1_3_next;

    always_comb begin
        qr3_next   = PN'((QW'(pr2_reg) * QW'(RECIP_R)) >> S_R);
        qc0_3_next = PN'((QW'(pc0_2_reg) * QW'(RECIP_C)) >> S_C);
        qc1_3_next = PN'((QW'(pc1_2_reg) * QW'(RECIP_C)) >> S_C);
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            it3_reg   <= it2_reg;
            qr3_reg   <= qr3_next;
            qc0_3_reg <= qc0_3_next;
            qc1_3_reg <= qc1_3_next;
        end
    end

    // ---------------- stage 4: clamp to the source edge ----------------
    logic [CW-1:0]      hm1, wm1;
    logic [CW-1:0]      r0_4_reg, r1_4_reg, r0_4_next, r1_4_next;
    logic [1:0][CW-1:0] c0_4_reg, c1_4_reg, c0_4_next, c1_4_next;
    logic [1:0][PN-1:0] qc3;

    assign hm1 = CW'(h_reg - DW'(1));
    assign wm1 = CW'(w_reg - DW'(1));
    assign qc3 = {qc1_3_reg, qc0_3_reg};

    always_comb begin
        r0_4_next = (qr3_reg > PN'(hm1)) ? hm1 : CW'(qr3_reg);
        r1_4_next = (r0_4_next == hm1) ? hm1 : CW'(r0_4_next + CW'(1));
        for (int p = 0; p < 2; p++) begin
            c0_4_next[p] = (qc3[p] > PN'(wm1)) ? wm1 : CW'(qc3[p]);
            c1_4_next[p] = (c0_4_next[p] == wm1) ? wm1 : CW'(c0_4_next[p] + CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            it4_reg  <= it3_reg;
            r0_4_reg <= r0_4_next;
            r1_4_reg <= r1_4_next;
            c0_4_reg <= c0_4_next;
            c1_4_reg <= c1_4_next;
        end
    end

    // ---------------- stage 5: frame store read / pixel load ----------------
    pdba_pkg::pdba_pix_wr_t pix_wr;
    logic [7:0][7:0]        codes5;

    always_comb begin
        pix_wr.en   = adv[4] && (it4_reg.action == pdba_pkg::ACT_LOAD_PIX);
        pix_wr.row  = it4_reg.src_row;
        pix_wr.col  = it4_reg.src_col;
        pix_wr.code = it4_reg.pixel_code;
    end

    pdba_frame_mem #(
        .SRC_MAX_DIM(SRC_MAX_DIM)
    ) u_frame (
        .aclk  (aclk),
        .rd_en (adv[4]),
        .row0  (r0_4_reg),
        .row1  (r1_4_reg),
        .col0  (c0_4_reg),
        .col1  (c1_4_reg),
        .wr    (pix_wr),
        .codes (codes5)
    );

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            it5_reg <= it4_reg;
        end
    end

    // ---------------- stage 6: palette read / palette load ----------------
    pdba_pkg::pdba_pal_wr_t pal_wr;
    logic [7:0][15:0]       colors6;
    req_t                   rq6_reg, rq7_reg;

    always_comb begin
        pal_wr.en    = adv[5] && (it5_reg.action == pdba_pkg::ACT_LOAD_PAL);
        pal_wr.index = it5_reg.pal_index;
        pal_wr.color = it5_reg.color;
    end

    pdba_pal_mem #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_pal (
        .aclk   (aclk),
        .rd_en  (adv[5]),
        .codes  (codes5),
        .wr     (pal_wr),
        .colors (colors6)
    );

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            rq6_reg <= '{action: it5_reg.action, blank: it5_reg.blank,
                         pair_x: it5_reg.pair_x, line_y: it5_reg.line_y};
        end
    end

    // ---------------- stage 7: top and bottom pair averages ----------------
    logic [1:0][15:0] top_reg, bot_reg, top_next, bot_next;

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            top_next[p] = pdba_pkg::avg565(colors6[p*4 + 0], colors6[p*4 + 1]);
            bot_next[p] = pdba_pkg::avg565(colors6[p*4 + 2], colors6[p*4 + 3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            rq7_reg <= rq6_reg;
            top_reg <= top_next;
            bot_reg <= bot_next;
        end
    end

    // ---------------- output register: final average, swap, pack ----------------
    pdba_pkg::pdba_out_t m_data_reg, m_data_next;
    logic [1:0][15:0]    pix;

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            pix[p] = pdba_pkg::avg565(top_reg[p], bot_reg[p]);
        end
        m_data_next.pair_word = rq7_reg.blank ? 32'h0000_0000
                              : {pdba_pkg::swap16(pix[1]), pdba_pkg::swap16(pix[0])};
        m_data_next.echo_x    = rq7_reg.pair_x;
        m_data_next.echo_y    = rq7_reg.line_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (free[8]) begin
            m_valid_reg <= adv[7] && (rq7_reg.action == pdba_pkg::ACT_REQ_PAIR);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------
    // a new result only comes from a pair request leaving the last stage
    a_result_from_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |->
            $past(vld_reg[7] && (rq7_reg.action == pdba_pkg::ACT_REQ_PAIR)))
        else $error("result without a pair request");

    // clamped coordinates stay inside the source frame
    a_coords_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[4] |-> (r0_4_reg <= r1_4_reg) && (r1_4_reg <= hm1)
                    && (c1_4_reg[0] <= wm1) && (c1_4_reg[1] <= wm1))
        else $error("source coordinate outside the frame");

    // usable size always saturated
    a_dims_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (w_reg >= DW'(2)) && (32'(w_reg) <= SRC_MAX_DIM)
        && (h_reg >= DW'(2)) && (32'(h_reg) <= SRC_MAX_DIM))
        else $error("source size out of range");

    // a blocked pair request in the last stage keeps its item and partial sums
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[7] && !adv[7] && (rq7_reg.action == pdba_pkg::ACT_REQ_PAIR)
        |=> vld_reg[7] && $stable(top_reg) && $stable(bot_reg))
        else $error("last stage changed while stalled");

endmodule

FILE: rtl/pdba_frame_mem.sv
// Source frame store: four banks split by row/column parity, two read ports each.
// Fetches the 2x2 block of codes for two output pixels per cycle while rd_en is high.
// Depends on pdba_pkg.
module pdba_frame_mem #(
    parameter int SRC_MAX_DIM = 256
) (
    input  logic                           aclk,
    input  logic                           rd_en,
    input  logic [$clog2(SRC_MAX_DIM)-1:0] row0,
    input  logic [$clog2(SRC_MAX_DIM)-1:0] row1,
    input  logic [1:0][$clog2(SRC_MAX_DIM)-1:0] col0,
    input  logic [1:0][$clog2(SRC_MAX_DIM)-1:0] col1,
    input  pdba_pkg::pdba_pix_wr_t         wr,
    // index p*4+j: pixel p, j = top-left, top-right, bottom-left, bottom-right
    output logic [7:0][7:0]                codes
);

    localparam int CW         = $clog2(SRC_MAX_DIM);
    localparam int HALF       = (SRC_MAX_DIM + 1) / 2;
    localparam int HW         = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int AW         = 2 * HW;
    localparam int BANK_DEPTH = 1 << AW;

    logic [1:0][7:0] rd_reg [4];
    logic            r0p_reg, r1p_reg;
    logic [1:0]      c0p_reg, c1p_reg;
    logic            wr_in_range;

    assign wr_in_range = (32'(wr.row) < SRC_MAX_DIM) && (32'(wr.col) < SRC_MAX_DIM);

    // banks: bank b holds rows with parity b[1] and columns with parity b[0]
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic BR = 1'((b >> 1) & 1);
        localparam logic BC = 1'(b & 1);

        logic [7:0]         mem [BANK_DEPTH];
        logic [1:0][AW-1:0] rd_addr;
        logic [AW-1:0]      wr_addr;
        logic               we;
        logic [CW-1:0]      row_sel;
        logic [1:0][CW-1:0] col_sel;

        always_comb begin
            row_sel = (row0[0] == BR) ? row0 : row1;
            for (int p = 0; p < 2; p++) begin
                col_sel[p] = (col0[p][0] == BC) ? col0[p] : col1[p];
                rd_addr[p] = {HW'(row_sel >> 1), HW'(col_sel[p] >> 1)};
            end
            wr_addr = {HW'(wr.row >> 1), HW'(wr.col >> 1)};
            we      = wr.en && wr_in_range && (wr.row[0] == BR) && (wr.col[0] == BC);
        end

        always_ff @(posedge aclk) begin
            if (we) begin
                mem[wr_addr] <= wr.code;
            end
            if (rd_en) begin
                rd_reg[b][0] <= mem[rd_addr[0]];
                rd_reg[b][1] <= mem[rd_addr[1]];
            end
        end
    end

    // parities decide which bank answers for each corner
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            r0p_reg <= row0[0];
            r1p_reg <= row1[0];
            c0p_reg <= {col0[1][0], col0[0][0]};
            c1p_reg <= {col1[1][0], col1[0][0]};
        end
    end

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            codes[p*4 + 0] = rd_reg[{r0p_reg, c0p_reg[p]}][p];
            codes[p*4 + 1] = rd_reg[{r0p_reg, c1p_reg[p]}][p];
            codes[p*4 + 2] = rd_reg[{r1p_reg, c0p_reg[p]}][p];
            codes[p*4 + 3] = rd_reg[{r1p_reg, c1p_reg[p]}][p];
        end
    end

endmodule

FILE: rtl/pdba_pal_mem.sv
// Palette store: four identical copies, two read ports each, eight lookups a cycle while rd_en is high.
// Codes outside the palette read as color zero. Depends on pdba_pkg.
module pdba_pal_mem #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                   aclk,
    input  logic                   rd_en,
    input  logic [7:0][7:0]        codes,
    input  pdba_pkg::pdba_pal_wr_t wr,
    output logic [7:0][15:0]       colors
);

    localparam int PW = $clog2(PALETTE_DEPTH);

    logic [1:0][15:0] rd_reg [4];
    logic [7:0]       oob_reg;
    logic             we;

    assign we = wr.en && (32'(wr.index) < PALETTE_DEPTH);

    // every write goes to all copies
    for (genvar k = 0; k < 4; k++) begin : g_copy
        logic [15:0] mem [PALETTE_DEPTH];

        always_ff @(posedge aclk) begin
            if (we) begin
                mem[PW'(wr.index)] <= wr.color;
            end
            if (rd_en) begin
                rd_reg[k][0] <= mem[PW'(codes[2*k])];
                rd_reg[k][1] <= mem[PW'(codes[2*k + 1])];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            for (int i = 0; i < 8; i++) begin
                oob_reg[i] <= (32'(codes[i]) >= PALETTE_DEPTH);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            colors[i] = oob_reg[i] ? 16'h0000 : rd_reg[i / 2][i % 2];
        end
    end

endmodule
